### hdl/rfo_pkg.sv
package rfo_pkg;

  localparam int CAPACITY   = 64;
  localparam int ELEM_WIDTH = 32;

  // fixed field widths of the stream payload
  localparam int DATA_W      = 32;
  localparam int CNT_W       = 16;
  localparam int LVL_OUT_W   = 7;
  localparam int CFG_W       = 7;
  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 2;

  // data_in is only 32 bits wide, so the store is never wider than 32 bits
  localparam int STORE_W = (ELEM_WIDTH < DATA_W) ? ELEM_WIDTH : DATA_W;
  localparam int PTR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LVL_W   = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_BPUSH = 2'd2,
    OP_BPOP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_OVWR  = 2'd2,
    ST_SHORT = 2'd3
  } status_e;

  typedef struct packed {
    logic               we;
    logic [PTR_W-1:0]   waddr;
    logic [STORE_W-1:0] wdata;
    logic               re;
    logic [PTR_W-1:0]   raddr;
  } mem_req_t;

endpackage

### hdl/rfo_mem.sv
module rfo_mem (
  input  logic                       clk_i,
  input  rfo_pkg::mem_req_t          req_i,
  output logic [rfo_pkg::STORE_W-1:0] rdata_o
);

  logic [rfo_pkg::STORE_W-1:0] mem_q [rfo_pkg::CAPACITY];
  logic [rfo_pkg::STORE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/rfo_adv.sv
module rfo_adv (
  input  logic [rfo_pkg::PTR_W-1:0] ptr_i,
  input  logic [rfo_pkg::LVL_W-1:0] depth_i,
  output logic [rfo_pkg::PTR_W-1:0] ptr_o
);

  logic [rfo_pkg::LVL_W-1:0] nxt;

  always_comb begin
    nxt   = rfo_pkg::LVL_W'(ptr_i) + rfo_pkg::LVL_W'(1);
    ptr_o = (nxt >= depth_i) ? '0 : rfo_pkg::PTR_W'(nxt);
  end

endmodule

### hdl/ring_fifo_with_overwrite.sv
// Circular FIFO with overwrite over a store of rfo_pkg::CAPACITY entries, of which
// depth_in_use are in use; any write of depth_in_use empties the FIFO. Items are handled
// one at a time by a small sequencer around a single pointer-advance unit and a memory
// with a registered read port. A push, a pop of an empty FIFO, a burst pop of too many
// entries or a burst element that ends a burst goes from idle through a decide state to an
// emit state, which loads the output register once it is free; other burst elements and
// burst pops of no entries go from the decide state back to idle without a result. A pop
// that returns entries passes a pop state, which reads the memory, and the emit state per
// entry. A result waiting in the output register does not stop the next item from being
// accepted. The store is not cleared; entries are read only after they were written.
module ring_fifo_with_overwrite (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rfo_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // data_in [31:0], burst_count [47:32]
  input  logic [rfo_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // opcode [1:0], overwrite [2], burst_first [3]
  input  logic [rfo_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // data_out [31:0], level [38:32], zero [39]
  output logic [rfo_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // status [1:0]
  output logic [rfo_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
  output logic                             m_axis_tlast
);

  localparam int PW = rfo_pkg::PTR_W;
  localparam int LW = rfo_pkg::LVL_W;
  localparam int CW = rfo_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECIDE = 4'b0010,
    S_POP    = 4'b0100,
    S_EMIT   = 4'b1000
  } state_e;

  state_e                       state_q, state_d;
  rfo_pkg::op_e                 op_q, op_d;
  logic                         ow_q, ow_d;
  logic [rfo_pkg::STORE_W-1:0]  data_q, data_d;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic                         first_q, first_d;
  logic                         blast_q, blast_d;
  logic [LW-1:0]                depth_q, depth_d;
  logic [PW-1:0]                wp_q, wp_d;
  logic [PW-1:0]                rp_q, rp_d;
  logic [LW-1:0]                level_q, level_d;
  logic                         rej_q, rej_d;
  logic                         ovf_q, ovf_d;
  logic [LW-1:0]                rem_q, rem_d;
  rfo_pkg::status_e             res_st_q, res_st_d;
  logic                         res_mem_q, res_mem_d;
  logic                         res_last_q, res_last_d;

  logic                         out_valid_q;
  logic [rfo_pkg::DATA_W-1:0]   out_data_q;
  logic [rfo_pkg::LVL_OUT_W-1:0] out_level_q;
  rfo_pkg::status_e             out_st_q;
  logic                         out_last_q;
  logic                         out_free;
  logic                         out_load;

  rfo_pkg::mem_req_t            mem_req;
  logic [rfo_pkg::STORE_W-1:0]  mem_rdata;
  logic [PW-1:0]                adv_in;
  logic [PW-1:0]                adv_out;

  logic                         full;
  logic                         do_store;
  logic                         rej_cur;
  logic                         ovf_cur;
  logic                         in_acc;

  rfo_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  rfo_adv u_adv (
    .ptr_i   (adv_in),
    .depth_i (depth_q),
    .ptr_o   (adv_out)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign full          = (level_q == depth_q);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    ow_d       = ow_q;
    data_d     = data_q;
    cnt_d      = cnt_q;
    first_d    = first_q;
    blast_d    = blast_q;
    depth_d    = depth_q;
    wp_d       = wp_q;
    rp_d       = rp_q;
    level_d    = level_q;
    rej_d      = rej_q;
    ovf_d      = ovf_q;
    rem_d      = rem_q;
    res_st_d   = res_st_q;
    res_mem_d  = res_mem_q;
    res_last_d = res_last_q;
    mem_req    = '0;
    adv_in     = wp_q;
    do_store   = 1'b0;
    out_load   = 1'b0;
    rej_cur    = rej_q;
    ovf_cur    = ovf_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d    = rfo_pkg::op_e'(s_axis_tuser[1:0]);
          ow_d    = s_axis_tuser[2];
          first_d = s_axis_tuser[3];
          data_d  = rfo_pkg::STORE_W'(s_axis_tdata[31:0]);
          cnt_d   = s_axis_tdata[47:32];
          blast_d = s_axis_tlast;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        res_mem_d  = 1'b0;
        res_last_d = 1'b1;
        case (op_q)
          rfo_pkg::OP_PUSH: begin
            if (full && !ow_q) begin
              res_st_d = rfo_pkg::ST_FULL;
            end else begin
              do_store = 1'b1;
              res_st_d = full ? rfo_pkg::ST_OVWR : rfo_pkg::ST_OK;
            end
            state_d = S_EMIT;
          end
          rfo_pkg::OP_POP: begin
            if (level_q == '0) begin
              res_st_d = rfo_pkg::ST_SHORT;
              state_d  = S_EMIT;
            end else begin
              rem_d   = LW'(1);
              state_d = S_POP;
            end
          end
          rfo_pkg::OP_BPUSH: begin
            if (first_q) begin
              rej_cur = ((CW+1)'(level_q) + (CW+1)'(cnt_q) > (CW+1)'(depth_q)) && !ow_q;
              ovf_cur = 1'b0;
            end
            if (!rej_cur) begin
              do_store = 1'b1;
              if (full) begin
                ovf_cur = 1'b1;
              end
            end
            if (blast_q) begin
              res_st_d = rej_cur ? rfo_pkg::ST_FULL
                       : (ovf_cur ? rfo_pkg::ST_OVWR : rfo_pkg::ST_OK);
              rej_d    = 1'b0;
              ovf_d    = 1'b0;
              state_d  = S_EMIT;
            end else begin
              rej_d   = rej_cur;
              ovf_d   = ovf_cur;
              state_d = S_IDLE;
            end
          end
          rfo_pkg::OP_BPOP: begin
            if ((CW+1)'(cnt_q) > (CW+1)'(level_q)) begin
              res_st_d = rfo_pkg::ST_SHORT;
              state_d  = S_EMIT;
            end else if (cnt_q == '0) begin
              state_d = S_IDLE;
            end else begin
              rem_d   = LW'(cnt_q);
              state_d = S_POP;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_POP: begin
        adv_in        = rp_q;
        mem_req.re    = 1'b1;
        mem_req.raddr = rp_q;
        rp_d          = adv_out;
        level_d       = level_q - LW'(1);
        rem_d         = rem_q - LW'(1);
        res_st_d      = rfo_pkg::ST_OK;
        res_mem_d     = 1'b1;
        res_last_d    = (rem_q == LW'(1));
        state_d       = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = res_last_q ? S_IDLE : S_POP;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // when full the read pointer sits on the write pointer, so one advance serves both
    if (do_store) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = wp_q;
      mem_req.wdata = data_q;
      wp_d          = adv_out;
      if (full) begin
        rp_d = adv_out;
      end else begin
        level_d = level_q + LW'(1);
      end
    end

    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        depth_d = LW'(1);
      end else if (int'(cfg_wdata_i) > rfo_pkg::CAPACITY) begin
        depth_d = LW'(rfo_pkg::CAPACITY);
      end else begin
        depth_d = LW'(cfg_wdata_i);
      end
      wp_d    = '0;
      rp_d    = '0;
      level_d = '0;
      rej_d   = 1'b0;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      depth_q <= LW'(rfo_pkg::CAPACITY);
      wp_q    <= '0;
      rp_q    <= '0;
      level_q <= '0;
      rej_q   <= 1'b0;
      ovf_q   <= 1'b0;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      level_q <= level_d;
      rej_q   <= rej_d;
      ovf_q   <= ovf_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    ow_q       <= ow_d;
    data_q     <= data_d;
    cnt_q      <= cnt_d;
    first_q    <= first_d;
    blast_q    <= blast_d;
    res_st_q   <= res_st_d;
    res_mem_q  <= res_mem_d;
    res_last_q <= res_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q  <= res_mem_q ? rfo_pkg::DATA_W'(mem_rdata) : '0;
      out_level_q <= rfo_pkg::LVL_OUT_W'(level_q);
      out_st_q    <= res_st_q;
      out_last_q  <= res_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_level_q, out_data_q};
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tlast  = out_last_q;

endmodule

### hdl/rfo_checker.sv
module rfo_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [rfo_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic [rfo_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);

  // a result that is not taken stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // the block works on one item at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted while previous item still in work");

  // the fill level never exceeds the store
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[38:32] <= 7'(rfo_pkg::CAPACITY)))
    else $error("level beyond capacity");

  // only a successful pop carries data
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != rfo_pkg::ST_OK) |-> (m_axis_tdata[31:0] == '0))
    else $error("data on a result that is not a pop");

endmodule

bind ring_fifo_with_overwrite rfo_checker u_rfo_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
